// ----- hdl/plc_pkg.sv -----
// shared types and codes for the positional list engine
package plc_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_DELETE = 2'd3
  } plc_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISSING = 2'd3
  } plc_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISOLATE,
    S_ENCODE
  } plc_state_e;

  // per-cycle move broadcast to every cell
  typedef struct packed {
    logic init;
    logic ins;
    logic del;
  } plc_ctl_t;

endpackage

// ----- hdl/plc_cell.sv -----
// one list cell: holds a value, shifts with its neighbors and compares to the key
module plc_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned PosW = 6,
  parameter int unsigned LenW = 7
) (
  input  logic                             clk_i,
  input  plc_pkg::plc_ctl_t                ctl_i,
  input  logic [PosW-1:0]                  pos_i,
  input  logic [LenW-1:0]                  count_i,
  input  logic [plc_pkg::DataW-1:0]        value_i,
  input  logic [plc_pkg::DataW-1:0]        prev_i,
  input  logic [plc_pkg::DataW-1:0]        next_i,
  output logic [plc_pkg::DataW-1:0]        q_o,
  output logic                             hit_o
);
  import plc_pkg::*;

  localparam logic [LenW-1:0] MyIdx = LenW'(IDX);

  logic [DataW-1:0] val_q;
  logic [DataW-1:0] val_d;
  logic [LenW-1:0]  pos_x;
  logic [LenW-1:0]  slot;

  assign pos_x = LenW'(pos_i);
  assign slot  = pos_x + LenW'(1);

  always_comb begin
    val_d = val_q;
    if (ctl_i.init) begin
      if (MyIdx == '0) val_d = value_i;
    end else if (ctl_i.ins) begin
      if (MyIdx == slot) begin
        val_d = value_i;
      end else if (MyIdx > slot) begin
        val_d = prev_i;
      end
    end else if (ctl_i.del) begin
      // close the gap from the deleted slot upward
      if (MyIdx >= pos_x) val_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign q_o   = val_q;
  assign hit_o = (MyIdx < count_i) && (val_q == value_i);

endmodule

// ----- hdl/plc_find.sv -----
// first-hit search: registers the hit row, isolates the lowest hit, encodes it
module plc_find #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned PosW     = 6
) (
  input  logic                clk_i,
  input  logic                capture_i,
  input  logic                isolate_i,
  input  logic [CAPACITY-1:0] hits_i,
  output logic                found_o,
  output logic [PosW-1:0]     index_o
);
  import plc_pkg::*;

  logic [CAPACITY-1:0] hits_q;
  logic [CAPACITY-1:0] oh_q;
  logic                found_q;

  always_ff @(posedge clk_i) begin
    if (capture_i) hits_q <= hits_i;
    if (isolate_i) begin
      // lowest set bit
      oh_q    <= hits_q & (~hits_q + CAPACITY'(1));
      found_q <= |hits_q;
    end
  end

  always_comb begin
    index_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (oh_q[i]) index_o = index_o | PosW'(i);
    end
  end

  assign found_o = found_q;

endmodule

// ----- hdl/positional_list_engine.sv -----
// top level of the positional list engine: command channel, cell row, result channel
//
// A bounded ordered list of 32-bit values held in a row of CAPACITY cells,
// cell 0 being the head. Each command word on the input channel gives one
// result word on the output channel (status, found index, new length).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Init, insert and delete act on all cells at once in the cycle the
// command is taken and the result shows up on the next cycle: one command
// per cycle while the output is free. Find registers the compare hits of
// all cells, isolates the lowest hit in a second register and encodes its
// index into the output register; no new command is taken while a find runs.
// The output register holds a result while the receiver stalls; outside a
// find the input is stalled only when that register is occupied and stalled.
// Reset empties the list (length 0) and drops any pending result; cell
// contents are not cleared, as only cells below the length are ever read.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned PosW = $clog2(CAPACITY),
  localparam int unsigned LenW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  plc_pkg::plc_cmd_e             command_i,
  input  logic signed [plc_pkg::DataW-1:0] value_i,
  input  logic [PosW-1:0]               position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output plc_pkg::plc_status_e          status_o,
  output logic [PosW-1:0]               found_index_o,
  output logic [LenW-1:0]               length_o
);
  import plc_pkg::*;

  plc_state_e        state_q, state_d;
  logic [LenW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  plc_status_e       status_q, status_d;
  logic [PosW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]   len_q, len_d;

  logic              accept;
  logic              out_free;
  logic              range_bad;
  logic              full;
  logic              capture;
  logic              isolate;
  logic              found;
  logic [PosW-1:0]   found_idx;
  plc_ctl_t          ctl;

  logic [DataW-1:0]    cell_val [CAPACITY];
  logic [CAPACITY-1:0] hits;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign range_bad = LenW'(position_i) >= count_q;
  assign full      = count_q == LenW'(CAPACITY);

  assign ctl.init = accept && (command_i == CMD_INIT);
  assign ctl.ins  = accept && (command_i == CMD_INSERT) && !range_bad && !full;
  assign ctl.del  = accept && (command_i == CMD_DELETE) && !range_bad;

  always_comb begin
    count_d = count_q;
    if (ctl.init) begin
      count_d = LenW'(1);
    end else if (ctl.ins) begin
      count_d = count_q + LenW'(1);
    end else if (ctl.del) begin
      count_d = count_q - LenW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    capture     = 1'b0;
    isolate     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    idx_d       = idx_q;
    len_d       = len_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_FIND) begin
            capture = 1'b1;
            state_d = S_ISOLATE;
          end else begin
            out_valid_d = 1'b1;
            idx_d       = '0;
            len_d       = count_d;
            status_d    = STAT_OK;
            if ((command_i == CMD_INSERT || command_i == CMD_DELETE) && range_bad) begin
              status_d = STAT_RANGE;
            end else if (command_i == CMD_INSERT && full) begin
              status_d = STAT_FULL;
            end
          end
        end
      end
      S_ISOLATE: begin
        isolate = 1'b1;
        state_d = S_ENCODE;
      end
      S_ENCODE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = found ? STAT_OK : STAT_MISSING;
          idx_d       = found ? found_idx : '0;
          len_d       = count_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    idx_q    <= idx_d;
    len_q    <= len_d;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plc_cell #(
      .IDX  (g),
      .PosW (PosW),
      .LenW (LenW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (position_i),
      .count_i (count_q),
      .value_i (value_i),
      .prev_i  (cell_val[(g == 0) ? 0 : g - 1]),
      .next_i  (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .q_o     (cell_val[g]),
      .hit_o   (hits[g])
    );
  end

  plc_find #(
    .CAPACITY (CAPACITY),
    .PosW     (PosW)
  ) u_find (
    .clk_i     (clk_i),
    .capture_i (capture),
    .isolate_i (isolate),
    .hits_i    (hits),
    .found_o   (found),
    .index_o   (found_idx)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = idx_q;
  assign length_o      = len_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LenW'(CAPACITY))
    else $error("list length above capacity");

  a_find_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_FIND) |=> state_q == S_ISOLATE ##1 state_q == S_ENCODE)
    else $error("find did not step through isolate and encode");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> count_q == $past(count_q) + LenW'(1))
    else $error("insert did not grow the list by one");

  a_missing_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> found_index_o == '0)
    else $error("nonzero index on a failed command");

endmodule
